// File: rtl/adcbv_pkg.sv
// Package for the ADC to battery voltage converter: field widths,
// calibration ROM contents and ROM lookup functions.
// Depends on nothing; imported by adc_to_battery_voltage_interp.
package adcbv_pkg;

    // Field and datapath widths
    localparam int ADC_W     = 12;  // ADC sample and breakpoint abscissa
    localparam int MV_W      = 16;  // breakpoint millivolts
    localparam int TEN_W     = 11;  // result in tenths of a volt
    localparam int IDX_W     = 4;   // ROM index
    localparam int ROM_DEPTH = 16;  // 2**IDX_W
    localparam int DX_W      = 12;  // segment width in ADC codes
    localparam int DY_W      = 17;  // segment rise in mV, signed
    localparam int DIFF_W    = 13;  // sample minus segment start, signed
    localparam int BASE_W    = 28;  // y0 * dx
    localparam int PROD_W    = 30;  // dy * (x - x0), signed
    localparam int NUM_W     = 31;  // interpolation numerator, signed
    localparam int DEN2_W    = 20;  // 200 * dx
    localparam int DVD_W     = 32;  // rounding dividend and remainder

    // Table lengths and defaults
    localparam int ZENER_LEN         = 14;
    localparam int PLAIN_LEN         = 8;
    localparam int TABLE_ENTRIES_DEF = 14;

    localparam logic [TEN_W-1:0] TENTHS_MAX = TEN_W'(2047);

    // Zener diode calibration, padded to the full ROM depth
    localparam logic [ADC_W-1:0] ZENER_ADC [ROM_DEPTH] = '{
        12'd614,  12'd725,  12'd841,  12'd960,  12'd1075, 12'd1190, 12'd1414, 12'd1703,
        12'd1856, 12'd2028, 12'd2156, 12'd2219, 12'd2302, 12'd2349, 12'd0,    12'd0
    };
    localparam logic [MV_W-1:0] ZENER_MV [ROM_DEPTH] = '{
        16'd5067,  16'd6052,  16'd7064,  16'd8076,  16'd9070,  16'd10098, 16'd12107,
        16'd15147, 16'd17178, 16'd20176, 16'd23228, 16'd25250, 16'd28266, 16'd30300,
        16'd0,     16'd0
    };

    // Plain divider calibration, padded to the full ROM depth
    localparam logic [ADC_W-1:0] PLAIN_ADC [ROM_DEPTH] = '{
        12'd589,  12'd710,  12'd827,  12'd942,  12'd1063, 12'd1175, 12'd1762, 12'd2336,
        12'd0,    12'd0,    12'd0,    12'd0,    12'd0,    12'd0,    12'd0,    12'd0
    };
    localparam logic [MV_W-1:0] PLAIN_MV [ROM_DEPTH] = '{
        16'd4974,  16'd6041,  16'd7060,  16'd8070,  16'd9088,  16'd10071, 16'd15178,
        16'd20244, 16'd0,     16'd0,     16'd0,     16'd0,     16'd0,     16'd0,
        16'd0,     16'd0
    };

    // Breakpoint abscissa; sel 1 picks the zener table
    function automatic logic [ADC_W-1:0] rom_adc(input logic sel,
                                                 input logic [IDX_W-1:0] idx);
        return sel ? ZENER_ADC[idx] : PLAIN_ADC[idx];
    endfunction

    // Breakpoint millivolts; sel 1 picks the zener table
    function automatic logic [MV_W-1:0] rom_mv(input logic sel,
                                               input logic [IDX_W-1:0] idx);
        return sel ? ZENER_MV[idx] : PLAIN_MV[idx];
    endfunction

endpackage

// File: rtl/adc_to_battery_voltage_interp.sv
// ADC to battery voltage converter: piecewise linear interpolation over a
// constant calibration ROM, then rounded division to tenths of a volt.
// Depends on adcbv_pkg.
//
// Usage
//   Input: an item (adc_sample) is taken at a clock edge with start high
//   and busy low. busy stays low: the pipeline takes an item every cycle.
//   Output: done pulses for one cycle with battery_tenths and clamped; the
//   receiver cannot hold results off, and none is needed as nothing stalls.
//   Config: table_select is written through cfg_valid/cfg_ready/cfg_data
//   (cfg_ready always high). Write it only while no item is in flight.
//   Stages: segment search, differences, products, numerator, rounding, divider
//   entry, an 11-stage restoring divider (one quotient bit per stage) and the
//   output register.
//   Throughput: one item per cycle, as every stage is registered and nothing
//   ever stalls.
//   Reset: all pipeline valid bits clear and table_select returns to 0
//   (plain divider table); items in flight are dropped.
//   Results below zero read 0, above 2047 read 2047; both raise clamped.
module adc_to_battery_voltage_interp
    import adcbv_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [ADC_W-1:0]  adc_sample,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_data,
    output logic              done,
    output logic [TEN_W-1:0]  battery_tenths,
    output logic              clamped
);

    // Entries used per table, at least two
    localparam int N_ZEN_RAW = (TABLE_ENTRIES > ZENER_LEN) ? ZENER_LEN : TABLE_ENTRIES;
    localparam int N_PLN_RAW = (TABLE_ENTRIES > PLAIN_LEN) ? PLAIN_LEN : TABLE_ENTRIES;
    localparam int N_ZEN     = (N_ZEN_RAW < 2) ? 2 : N_ZEN_RAW;
    localparam int N_PLN     = (N_PLN_RAW < 2) ? 2 : N_PLN_RAW;
    localparam logic [IDX_W-1:0] LAST_SEG_ZEN = IDX_W'(N_ZEN - 2);
    localparam logic [IDX_W-1:0] LAST_SEG_PLN = IDX_W'(N_PLN - 2);
    localparam int LATENCY = 6 + TEN_W + 1;

    // Configuration register
    logic table_sel_reg;

    // Stage 1: segment ends
    logic                    s1_valid_reg;
    logic [ADC_W-1:0]        s1_x_reg, s1_x0_reg, s1_x1_reg;
    logic [MV_W-1:0]         s1_y0_reg, s1_y1_reg;
    logic [ADC_W-1:0]        s1_x0_next, s1_x1_next;
    logic [MV_W-1:0]         s1_y0_next, s1_y1_next;
    logic [IDX_W-1:0]        seg_lo, seg_hi, last_seg;

    // Stage 2: differences
    logic                    s2_valid_reg;
    logic signed [DIFF_W-1:0] s2_diff_reg, s2_diff_next;
    logic [DX_W-1:0]         s2_dx_reg, s2_dx_next;
    logic signed [DY_W-1:0]  s2_dy_reg, s2_dy_next;
    logic [MV_W-1:0]         s2_y0_reg;

    // Stage 3: products
    logic                    s3_valid_reg;
    logic [BASE_W-1:0]       s3_base_reg, s3_base_next;
    logic signed [PROD_W-1:0] s3_prod_reg, s3_prod_next;
    logic [DEN2_W-1:0]       s3_den2_reg, s3_den2_next;

    // Stage 4: numerator
    logic                    s4_valid_reg;
    logic signed [NUM_W-1:0] s4_num_reg, s4_num_next;
    logic [DEN2_W-1:0]       s4_den2_reg;

    // Stage 5: rounding dividend and negative clamp
    logic                    s5_valid_reg;
    logic [DVD_W-1:0]        s5_dvd_reg, s5_dvd_next;
    logic                    s5_negc_reg, s5_negc_next;
    logic [DEN2_W-1:0]       s5_den2_reg;
    logic [DVD_W-1:0]        twice_num, den_ext;
    logic                    num_neg;

    // Divider stages; index 0 holds the overflow check result
    logic                    dv_valid_reg [0:TEN_W];
    logic [DVD_W-1:0]        dv_rem_reg   [0:TEN_W];
    logic [TEN_W-1:0]        dv_q_reg     [0:TEN_W];
    logic [DEN2_W-1:0]       dv_den2_reg  [0:TEN_W];
    logic                    dv_ovf_reg   [0:TEN_W];
    logic                    dv_negc_reg  [0:TEN_W];
    logic                    dv0_ovf_next;

    // Output register
    logic                    done_reg;
    logic [TEN_W-1:0]        tenths_reg, tenths_next;
    logic                    clamped_reg, clamped_next;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // Table select register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_sel_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            table_sel_reg <= cfg_data;
        end
    end

    // Stage 1: first bracketing segment, else extrapolate at either end
    always_comb
    begin
        last_seg = table_sel_reg ? LAST_SEG_ZEN : LAST_SEG_PLN;
        seg_lo   = last_seg;
        for (int i = ROM_DEPTH - 2; i >= 0; i--)
        begin
            if (IDX_W'(i) <= last_seg
                && rom_adc(table_sel_reg, IDX_W'(i)) <= adc_sample
                && rom_adc(table_sel_reg, IDX_W'(i + 1)) >= adc_sample)
            begin
                seg_lo = IDX_W'(i);
            end
        end
        if (adc_sample < rom_adc(table_sel_reg, '0))
        begin
            seg_lo = '0;
        end
        seg_hi     = seg_lo + IDX_W'(1);
        s1_x0_next = rom_adc(table_sel_reg, seg_lo);
        s1_x1_next = rom_adc(table_sel_reg, seg_hi);
        s1_y0_next = rom_mv(table_sel_reg, seg_lo);
        s1_y1_next = rom_mv(table_sel_reg, seg_hi);
    end

    // Stage 2: segment width, rise and sample offset
    always_comb
    begin
        s2_diff_next = signed'({1'b0, s1_x_reg}) - signed'({1'b0, s1_x0_reg});
        s2_dx_next   = s1_x1_reg - s1_x0_reg;
        s2_dy_next   = signed'({1'b0, s1_y1_reg}) - signed'({1'b0, s1_y0_reg});
    end

    // Stage 3: y0*dx, dy*(x-x0), and 200*dx by shifts
    always_comb
    begin
        s3_base_next = BASE_W'(s2_y0_reg) * BASE_W'(s2_dx_reg);
        s3_prod_next = PROD_W'(s2_dy_reg) * PROD_W'(s2_diff_reg);
        s3_den2_next = DEN2_W'({s2_dx_reg, 7'b0}) + DEN2_W'({s2_dx_reg, 6'b0})
                     + DEN2_W'({s2_dx_reg, 3'b0});
    end

    // Stage 4: numerator
    always_comb
    begin
        s4_num_next = signed'({{(NUM_W - BASE_W){1'b0}}, s3_base_reg})
                    + NUM_W'(s3_prod_reg);
    end

    // Stage 5: half away from zero; a negative numerator only flags
    always_comb
    begin
        num_neg   = s4_num_reg[NUM_W-1];
        twice_num = DVD_W'({s4_num_reg, 1'b0});
        den_ext   = DVD_W'(s4_den2_reg >> 1);
        if (num_neg)
        begin
            s5_dvd_next  = '0;
            s5_negc_next = (DVD_W'(0) - twice_num) >= den_ext;
        end
        else
        begin
            s5_dvd_next  = twice_num + den_ext;
            s5_negc_next = 1'b0;
        end
    end

    // Divider entry: quotient of 2048 or more saturates
    always_comb
    begin
        dv0_ovf_next = s5_dvd_reg >= (DVD_W'(s5_den2_reg) << TEN_W);
    end

    // Front stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            s2_valid_reg    <= 1'b0;
            s3_valid_reg    <= 1'b0;
            s4_valid_reg    <= 1'b0;
            s5_valid_reg    <= 1'b0;
            dv_valid_reg[0] <= 1'b0;
        end
        else
        begin
            s1_valid_reg    <= start && !busy;
            s2_valid_reg    <= s1_valid_reg;
            s3_valid_reg    <= s2_valid_reg;
            s4_valid_reg    <= s3_valid_reg;
            s5_valid_reg    <= s4_valid_reg;
            dv_valid_reg[0] <= s5_valid_reg;
        end
    end

    // Front stage payload
    always_ff @(posedge clk)
    begin
        s1_x_reg       <= adc_sample;
        s1_x0_reg      <= s1_x0_next;
        s1_x1_reg      <= s1_x1_next;
        s1_y0_reg      <= s1_y0_next;
        s1_y1_reg      <= s1_y1_next;
        s2_diff_reg    <= s2_diff_next;
        s2_dx_reg      <= s2_dx_next;
        s2_dy_reg      <= s2_dy_next;
        s2_y0_reg      <= s1_y0_reg;
        s3_base_reg    <= s3_base_next;
        s3_prod_reg    <= s3_prod_next;
        s3_den2_reg    <= s3_den2_next;
        s4_num_reg     <= s4_num_next;
        s4_den2_reg    <= s3_den2_reg;
        s5_dvd_reg     <= s5_dvd_next;
        s5_negc_reg    <= s5_negc_next;
        s5_den2_reg    <= s4_den2_reg;
        dv_rem_reg[0]  <= s5_dvd_reg;
        dv_q_reg[0]    <= '0;
        dv_den2_reg[0] <= s5_den2_reg;
        dv_ovf_reg[0]  <= dv0_ovf_next;
        dv_negc_reg[0] <= s5_negc_reg;
    end

    // Restoring divider, one quotient bit per stage, MSB first
    for (genvar j = 0; j < TEN_W; j++)
    begin : g_div
        localparam int SH = TEN_W - 1 - j;
        logic [DVD_W-1:0] trial;
        logic             take;
        logic [DVD_W-1:0] rem_next;
        logic [TEN_W-1:0] q_next;

        always_comb
        begin
            trial    = DVD_W'(dv_den2_reg[j]) << SH;
            take     = dv_rem_reg[j] >= trial;
            rem_next = take ? (dv_rem_reg[j] - trial) : dv_rem_reg[j];
            q_next   = dv_q_reg[j];
            q_next[SH] = take;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_valid_reg[j+1] <= 1'b0;
            end
            else
            begin
                dv_valid_reg[j+1] <= dv_valid_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            dv_rem_reg[j+1]  <= rem_next;
            dv_q_reg[j+1]    <= q_next;
            dv_den2_reg[j+1] <= dv_den2_reg[j];
            dv_ovf_reg[j+1]  <= dv_ovf_reg[j];
            dv_negc_reg[j+1] <= dv_negc_reg[j];
        end
    end

    // Saturation and clamp flag
    always_comb
    begin
        tenths_next  = dv_ovf_reg[TEN_W] ? TENTHS_MAX : dv_q_reg[TEN_W];
        clamped_next = dv_ovf_reg[TEN_W] || dv_negc_reg[TEN_W];
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dv_valid_reg[TEN_W];
        end
    end

    always_ff @(posedge clk)
    begin
        tenths_reg  <= tenths_next;
        clamped_reg <= clamped_next;
    end

    assign done           = done_reg;
    assign battery_tenths = tenths_reg;
    assign clamped        = clamped_reg;

    // A result only ever follows an accepted item by the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without matching item");

    // A clamped result sits at one of the two limits
    a_clamp_value: assert property (@(posedge clk) disable iff (!rst_n)
        done && clamped |-> (battery_tenths == '0 || battery_tenths == TENTHS_MAX))
        else $error("clamped result not at a limit");

    // Negative clamp and overflow exclude each other
    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        dv_valid_reg[0] |-> !(dv_ovf_reg[0] && dv_negc_reg[0]))
        else $error("negative and overflow both set");

    // Divider leaves a remainder below the divisor
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        dv_valid_reg[TEN_W] && !dv_ovf_reg[TEN_W]
            |-> dv_rem_reg[TEN_W] < DVD_W'(dv_den2_reg[TEN_W]))
        else $error("divider remainder out of range");

endmodule

// File: test/tb.sv
// Testbench for adc_to_battery_voltage_interp: ADC samples are sent under both calibration
// tables and every result is checked against an in-bench interpolation of the same breakpoints.
// Depends on adcbv_pkg and the adc_to_battery_voltage_interp RTL.
module tb;
    import adcbv_pkg::*;

    localparam int SETTLE_CYCLES = 40;    // well past the pipeline latency
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 200;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [ADC_W-1:0]  adc_sample = '0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic              cfg_data = 1'b0;
    logic              done;
    logic [TEN_W-1:0]  battery_tenths;
    logic              clamped;

    bit no_gaps = 1'b0;

    // Calibration breakpoints (adc code, millivolts)
    function automatic void breakpoint(input bit zener, input int idx,
                                       output longint ax, output longint mv);
        if (zener)
        begin
            case (idx)
                0:       {ax, mv} = {64'd614,  64'd5067};
                1:       {ax, mv} = {64'd725,  64'd6052};
                2:       {ax, mv} = {64'd841,  64'd7064};
                3:       {ax, mv} = {64'd960,  64'd8076};
                4:       {ax, mv} = {64'd1075, 64'd9070};
                5:       {ax, mv} = {64'd1190, 64'd10098};
                6:       {ax, mv} = {64'd1414, 64'd12107};
                7:       {ax, mv} = {64'd1703, 64'd15147};
                8:       {ax, mv} = {64'd1856, 64'd17178};
                9:       {ax, mv} = {64'd2028, 64'd20176};
                10:      {ax, mv} = {64'd2156, 64'd23228};
                11:      {ax, mv} = {64'd2219, 64'd25250};
                12:      {ax, mv} = {64'd2302, 64'd28266};
                default: {ax, mv} = {64'd2349, 64'd30300};
            endcase
        end
        else
        begin
            case (idx)
                0:       {ax, mv} = {64'd589,  64'd4974};
                1:       {ax, mv} = {64'd710,  64'd6041};
                2:       {ax, mv} = {64'd827,  64'd7060};
                3:       {ax, mv} = {64'd942,  64'd8070};
                4:       {ax, mv} = {64'd1063, 64'd9088};
                5:       {ax, mv} = {64'd1175, 64'd10071};
                6:       {ax, mv} = {64'd1762, 64'd15178};
                default: {ax, mv} = {64'd2336, 64'd20244};
            endcase
        end
    endfunction

    // Breakpoints in use: min(TABLE_ENTRIES, table length), TABLE_ENTRIES is 14
    function automatic int table_len(input bit zener);
        return zener ? 14 : 8;
    endfunction

    typedef struct {
        logic [ADC_W-1:0] adc;
        logic [TEN_W-1:0] tenths;
        logic             clamped;
    } tenths_t;

    // Tracks the table in use and the voltages still owed by the block
    class tenths_tracker;
        bit      zener_sel;
        tenths_t owed[$];
        int      errors;
        int      reported;

        function new();
            zener_sel = 1'b0;
            errors    = 0;
            reported  = 0;
        endfunction

        // Interpolate, round half away from zero, clamp to 0..2047
        function tenths_t tenths_from_adc(input logic [ADC_W-1:0] adc);
            tenths_t r;
            int      n;
            int      seg;
            longint  x, ax0, mv0, ax1, mv1, dx, dy, num, den, q;
            n   = table_len(zener_sel);
            x   = longint'(adc);
            seg = -1;
            for (int i = 0; i < n - 1; i++)
            begin
                breakpoint(zener_sel, i, ax0, mv0);
                breakpoint(zener_sel, i + 1, ax1, mv1);
                if (seg < 0 && ax0 <= x && ax1 >= x)
                    seg = i;
            end
            if (seg < 0)
            begin
                breakpoint(zener_sel, 0, ax0, mv0);
                seg = (x < ax0) ? 0 : n - 2;
            end
            breakpoint(zener_sel, seg, ax0, mv0);
            breakpoint(zener_sel, seg + 1, ax1, mv1);
            dx  = ax1 - ax0;
            dy  = mv1 - mv0;
            num = mv0 * dx + dy * (x - ax0);
            den = 100 * dx;
            if (num >= 0)
                q = (2 * num + den) / (2 * den);
            else
                q = -((-2 * num + den) / (2 * den));
            r.adc     = adc;
            r.clamped = 1'b0;
            if (q < 0)
            begin
                q = 0;
                r.clamped = 1'b1;
            end
            else if (q > 2047)
            begin
                q = 2047;
                r.clamped = 1'b1;
            end
            r.tenths = TEN_W'(q);
            return r;
        endfunction

        function void note_sample(input logic [ADC_W-1:0] adc);
            owed.push_back(tenths_from_adc(adc));
        endfunction

        function void check_result(input logic [TEN_W-1:0] tenths, input logic clmp);
            tenths_t e;
            if (owed.size() == 0)
            begin
                errors++;
                if (reported < 10)
                begin
                    reported++;
                    $display("unexpected result: tenths=%0d clamped=%0d", tenths, clmp);
                end
                return;
            end
            e = owed.pop_front();
            if (tenths !== e.tenths || clmp !== e.clamped)
            begin
                errors++;
                if (reported < 10)
                begin
                    reported++;
                    $display("adc=%0d expected tenths=%0d clamped=%0d,", e.adc, e.tenths,
                             e.clamped, " got tenths=%0d clamped=%0d", tenths, clmp);
                end
            end
        endfunction

        function int pending();
            return owed.size();
        endfunction
    endclass

    tenths_tracker volts = new();

    adc_to_battery_voltage_interp u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .adc_sample     (adc_sample),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .done           (done),
        .battery_tenths (battery_tenths),
        .clamped        (clamped)
    );

    // Clock, period 10
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Monitor: values read here are those before the edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                volts.zener_sel = cfg_data;
            if (start && !busy)
                volts.note_sample(adc_sample);
            if (done)
                volts.check_result(battery_tenths, clamped);
        end
    end

    // Send one item after a random gap; returns at the edge that takes it
    task automatic send_sample(input logic [ADC_W-1:0] v);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        adc_sample <= v;
        do @(posedge clk); while (busy);
    endtask

    // Wait until every owed result has come back
    task automatic wait_drained();
        do @(posedge clk); while (volts.pending() != 0);
    endtask

    task automatic write_table_select(input bit zener);
        cfg_valid <= 1'b1;
        cfg_data  <= zener;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Random sample: uniform, near a breakpoint, or in the low clamp region
    function automatic logic [ADC_W-1:0] pick_sample(input bit zener);
        int     r;
        int     v;
        longint ax, mv;
        r = $urandom_range(0, 9);
        if (r < 5)
            return ADC_W'($urandom);
        if (r < 8)
        begin
            breakpoint(zener, $urandom_range(0, table_len(zener) - 1), ax, mv);
            v = int'(ax) + $urandom_range(0, 6) - 3;
            return ADC_W'(v);
        end
        return ADC_W'($urandom_range(0, 80));
    endfunction

    // Zero, full scale, the zero crossings of both tables, breakpoint ties
    int directed[13] = '{0, 4095, 19, 20, 24, 25, 37, 38, 589, 614, 1762, 2336, 2349};

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, plain table from reset, then zener
        foreach (directed[i])
            send_sample(ADC_W'(directed[i]));
        start <= 1'b0;
        wait_drained();
        write_table_select(1'b1);
        foreach (directed[i])
            send_sample(ADC_W'(directed[i]));
        start <= 1'b0;
        wait_drained();

        // Random phases, alternating tables
        for (int ph = 0; ph < PHASES; ph++)
        begin
            write_table_select(ph[0]);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (k % 40 == 0)
                    no_gaps = ($urandom_range(0, 3) == 0);
                send_sample(pick_sample(ph[0]));
            end
            start <= 1'b0;
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (volts.pending() != 0)
        begin
            volts.errors++;
            $display("%0d results never arrived", volts.pending());
        end
        if (volts.errors == 0)
            $display("adc_to_battery_voltage_interp: match");
        else
            $display("adc_to_battery_voltage_interp: mismatch");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("adc_to_battery_voltage_interp: mismatch");
        $finish;
    end

endmodule
